// ===== rtl/softab_pkg.sv =====
// Package for the socket owner flow table: field structs, action and status codes, sizes.
// Used by every module in rtl.
package softab_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_ATTACH = 2'd2,
        ACT_LOOKUP = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_FULL    = 3'd2,
        ST_DUP     = 3'd3,
        ST_NOMATCH = 3'd4,
        ST_OWNED   = 3'd5,
        ST_SELF    = 3'd6
    } t_status;

    localparam logic [1:0] CFG_SELF_ADDR = 2'd0;
    localparam logic [1:0] CFG_SELF_PORT = 2'd1;
    localparam logic [1:0] CFG_SELF_PID  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  proto;
        logic [31:0] addr_first;
        logic [31:0] addr_second;
        logic [15:0] port_first;
        logic [15:0] port_second;
        logic [31:0] socket_id;
        logic [22:0] proc_id;
        logic        fresh_fill;
        logic        allow_self;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [22:0] owner_id;
        logic [2:0]  status;
        logic [7:0]  entry_count;
    } t_out_item;

    // classified command handed from front to back
    typedef struct packed {
        t_in_item item;
        logic     bad_insert;
    } t_cmd;

    typedef struct packed {
        logic [31:0] self_addr;
        logic [15:0] self_port;
        logic [22:0] self_proc_id;
    } t_cfg;

endpackage

// ===== rtl/softab_front.sv =====
// Front end: takes commands, flags invalid inserts, pushes into a short queue.
// Depends on softab_pkg.
module softab_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  softab_pkg::t_in_item i_item,
    output logic              o_busy,
    input  logic              i_pop,
    output logic              o_valid,
    output softab_pkg::t_cmd  o_cmd
);
    import softab_pkg::*;

    t_cmd         r_q [QUEUE_DEPTH];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt, n_cnt;
    logic         push;
    t_cmd         new_cmd;

    // sequential block: one item in flight between start and its pop by the back end
    logic r_inflight, n_inflight;

    assign o_busy  = r_inflight;
    assign push    = i_start && !r_inflight;
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_comb begin
        new_cmd.item       = i_item;
        new_cmd.bad_insert = (i_item.socket_id == '0) || (i_item.addr_first == '0)
                           || (i_item.addr_second == '0);
    end

    always_comb begin
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_pop};
        n_inflight = r_inflight;
        if (push) begin
            n_inflight = 1'b1;
        end else if (i_pop) begin
            n_inflight = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= new_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
            r_inflight <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
            r_inflight <= n_inflight;
        end
    end
endmodule

// ===== rtl/softab_back.sv =====
// Back end: holds the table memory and scans it one entry a cycle per command.
// Depends on softab_pkg.
module softab_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  softab_pkg::t_cmd  i_cmd,
    input  softab_pkg::t_cfg  i_cfg,
    output logic              o_pop,
    output logic              o_done,
    output softab_pkg::t_out_item o_result
);
    import softab_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_READ  = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    localparam int ENT_W = 8 + 64 + 32 + 32;

    logic [ENT_W-1:0] mem_key [TABLE_DEPTH];
    logic [22:0]      mem_own [TABLE_DEPTH];

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic [ENT_W-1:0] r_key;
    logic [22:0]  r_own;
    logic         r_rd_ok;
    logic         r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [22:0]  r_hit_own;
    logic         r_done;
    t_out_item    r_res, n_res;

    logic [7:0]  e_proto;
    logic [63:0] e_addrs;
    logic [31:0] e_ports;
    logic [31:0] e_sock;
    logic        match;
    logic        scan_end;

    assign {e_proto, e_addrs, e_ports, e_sock} = r_key;
    assign o_pop    = (r_state == S_IDLE) && i_valid;
    assign o_done   = r_done;
    assign o_result = r_res;

    always_comb begin
        if (r_cmd.item.action == ACT_LOOKUP) begin
            match = (e_proto == r_cmd.item.proto) && (
                ((e_addrs == {r_cmd.item.addr_first, r_cmd.item.addr_second}) &&
                 (e_ports == {r_cmd.item.port_first, r_cmd.item.port_second})) ||
                ((e_addrs == {r_cmd.item.addr_second, r_cmd.item.addr_first}) &&
                 (e_ports == {r_cmd.item.port_second, r_cmd.item.port_first})));
        end else begin
            match = (e_sock == r_cmd.item.socket_id);
        end
        scan_end = (r_idx >= r_count);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_SCAN;
            S_SCAN: begin
                if ((r_rd_ok && match) || (!r_rd_ok && scan_end)) n_state = S_FIN;
            end
            S_READ:  n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // result word of the finished command
    always_comb begin
        n_res             = '0;
        n_res.status      = ST_OK;
        n_res.entry_count = 8'(r_count);
        case (t_action'(r_cmd.item.action))
            ACT_CLEAR: n_res.entry_count = '0;
            ACT_INSERT: begin
                if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                    n_res.status = ST_FULL;
                end else if (r_cmd.bad_insert) begin
                    n_res.status = ST_INVALID;
                end else if (r_hit) begin
                    n_res.status = ST_DUP;
                end else begin
                    n_res.entry_count = 8'(r_count + 1'b1);
                end
            end
            ACT_ATTACH: begin
                if (!r_hit) n_res.status = ST_NOMATCH;
                else if (r_hit_own != '0) n_res.status = ST_OWNED;
            end
            ACT_LOOKUP: begin
                if (r_hit) begin
                    n_res.found    = 1'b1;
                    n_res.owner_id = r_hit_own;
                end else if (r_cmd.item.allow_self &&
                             r_cmd.item.addr_second == i_cfg.self_addr &&
                             r_cmd.item.port_second == i_cfg.self_port) begin
                    n_res.found    = 1'b1;
                    n_res.owner_id = i_cfg.self_proc_id;
                    n_res.status   = ST_SELF;
                end else begin
                    n_res.status = ST_NOMATCH;
                end
            end
            default: n_res.status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        // registered read of the table, one entry a cycle
        r_key <= mem_key[r_idx[IDX_W-1:0]];
        r_own <= mem_own[r_idx[IDX_W-1:0]];
        if (r_state == S_FIN) begin
            if (r_cmd.item.action == ACT_INSERT && !r_hit && r_count < CNT_W'(TABLE_DEPTH)
                && !r_cmd.bad_insert) begin
                mem_key[r_count[IDX_W-1:0]] <= {r_cmd.item.proto, r_cmd.item.addr_first,
                    r_cmd.item.addr_second, r_cmd.item.port_first,
                    r_cmd.item.port_second, r_cmd.item.socket_id};
                mem_own[r_count[IDX_W-1:0]] <= '0;
            end else if (r_cmd.item.action == ACT_ATTACH && r_hit && r_hit_own == '0) begin
                mem_own[r_hit_idx] <= r_cmd.item.proc_id;
            end
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FIN);
            case (r_state)
                S_IDLE: begin
                    r_cmd   <= i_cmd;
                    r_idx   <= '0;
                    r_rd_ok <= 1'b0;
                    r_hit   <= 1'b0;
                    r_hit_own <= '0;
                end
                S_SCAN: begin
                    // skip the scan for clear and for inserts that never need it
                    if (r_cmd.item.action == ACT_CLEAR ||
                        (r_cmd.item.action == ACT_INSERT &&
                         (r_cmd.item.fresh_fill || r_cmd.bad_insert))) begin
                        r_rd_ok <= 1'b0;
                        r_idx   <= r_count;
                    end else if (r_rd_ok && match) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= IDX_W'(r_idx - 1'b1);
                        r_hit_own <= r_own;
                    end else if (!scan_end) begin
                        r_idx   <= r_idx + 1'b1;
                        r_rd_ok <= 1'b1;
                    end else begin
                        r_rd_ok <= 1'b0;
                    end
                end
                S_FIN: begin
                    r_res <= n_res;
                    if (r_cmd.item.action == ACT_CLEAR) begin
                        r_count <= '0;
                    end else if (r_cmd.item.action == ACT_INSERT && n_res.status == ST_OK) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                default: r_rd_ok <= 1'b0;
            endcase
        end
    end
endmodule

// ===== rtl/socket_owner_flow_table.sv =====
// Top level of the socket owner flow table: front, back and configuration registers.
// Depends on softab_pkg, softab_front and softab_back.
//
// Usage: raise start with the command on i_cmd while busy is low; the command
// is taken at that edge. One command is processed at a time. The result appears
// on o_result with o_done high for exactly one cycle; it cannot be held off.
// Insert (with duplicate check), attach and lookup scan the entries in order until
// a match or the entry count (at most 128 entries) is reached. Clear and inserts
// that skip the check do not scan. A new command can be accepted during a scan;
// it waits in the queue. The scan reads one table entry per cycle from the table
// memory's single read port.
// Configuration: write i_cfg_index/i_cfg_data with i_cfg_valid; o_cfg_ready is
// always high. Write only while the block is idle.
// Reset clears the entry count and the self-traffic registers; table contents
// are not cleared and are never read before being written.
module socket_owner_flow_table (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  softab_pkg::t_in_item  i_cmd,
    output logic                  o_done,
    output softab_pkg::t_out_item o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    import softab_pkg::*;

    t_cfg  r_cfg;
    logic  q_valid, q_pop;
    t_cmd  q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SELF_ADDR: r_cfg.self_addr    <= i_cfg_data;
                CFG_SELF_PORT: r_cfg.self_port    <= i_cfg_data[15:0];
                CFG_SELF_PID:  r_cfg.self_proc_id <= i_cfg_data[22:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    softab_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_cmd),
        .o_busy  (busy),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    softab_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (q_cmd),
        .i_cfg    (r_cfg),
        .o_pop    (q_pop),
        .o_done   (o_done),
        .o_result (o_result)
    );
endmodule

// ===== rtl/softab_checker.sv =====
// Port-level checker for the socket owner flow table, bound to the top level.
// Depends on softab_pkg.
module softab_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_done,
    input softab_pkg::t_out_item o_result
);
    import softab_pkg::*;

    // accepted command makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy not raised after start");

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held longer than one cycle");

    // a found result carries status OK or self
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.found |-> (o_result.status == ST_OK || o_result.status == ST_SELF))
        else $error("found with wrong status");

    // count never exceeds the table depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.entry_count <= 8'(TABLE_DEPTH)) else $error("count overflow");
endmodule

bind socket_owner_flow_table softab_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== test/socket_owner_flow_table_chk.sv =====
// Checker for the socket owner flow table: watches commands, config writes and results,
// predicts each result with its own table model and compares field by field.
// Depends on softab_pkg.
module socket_owner_flow_table_chk (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  softab_pkg::t_in_item  i_cmd,
    input  logic      i_done,
    input  softab_pkg::t_out_item i_result,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_hits,
    output int        o_self_hits
);
    timeunit 1ns;
    timeprecision 1ps;
    import softab_pkg::*;

    logic [7:0]  proto_tab [TABLE_DEPTH];
    logic [31:0] local_addr_tab [TABLE_DEPTH];
    logic [31:0] remote_addr_tab [TABLE_DEPTH];
    logic [15:0] local_port_tab [TABLE_DEPTH];
    logic [15:0] remote_port_tab [TABLE_DEPTH];
    logic [31:0] sock_tab [TABLE_DEPTH];
    logic [22:0] owner_tab [TABLE_DEPTH];
    int          entries;
    t_cfg        self_cfg;
    t_out_item   owner_results_q [$];

    function automatic int first_socket(logic [31:0] sid);
        for (int i = 0; i < entries; i++)
            if (sock_tab[i] == sid) return i;
        return entries;
    endfunction

    function automatic t_out_item apply_command(t_in_item c);
        t_out_item r;
        int        k;
        r = '0;
        r.status = ST_OK;
        case (t_action'(c.action))
            ACT_CLEAR: entries = 0;
            ACT_INSERT: begin
                if (entries >= TABLE_DEPTH) r.status = ST_FULL;
                else if (c.socket_id == 0 || c.addr_first == 0 || c.addr_second == 0)
                    r.status = ST_INVALID;
                else if (!c.fresh_fill && first_socket(c.socket_id) < entries)
                    r.status = ST_DUP;
                else begin
                    proto_tab[entries]       = c.proto;
                    local_addr_tab[entries]  = c.addr_first;
                    remote_addr_tab[entries] = c.addr_second;
                    local_port_tab[entries]  = c.port_first;
                    remote_port_tab[entries] = c.port_second;
                    sock_tab[entries]        = c.socket_id;
                    owner_tab[entries]       = '0;
                    entries++;
                end
            end
            ACT_ATTACH: begin
                k = first_socket(c.socket_id);
                if (k >= entries) r.status = ST_NOMATCH;
                else if (owner_tab[k] != 0) r.status = ST_OWNED;
                else owner_tab[k] = c.proc_id;
            end
            default: begin
                r.status = ST_NOMATCH;
                for (int i = 0; i < entries; i++) begin
                    if (proto_tab[i] != c.proto) continue;
                    if ((local_addr_tab[i] == c.addr_first && remote_addr_tab[i] == c.addr_second
                         && local_port_tab[i] == c.port_first
                         && remote_port_tab[i] == c.port_second) ||
                        (local_addr_tab[i] == c.addr_second && remote_addr_tab[i] == c.addr_first
                         && local_port_tab[i] == c.port_second
                         && remote_port_tab[i] == c.port_first)) begin
                        r.found = 1'b1;
                        r.owner_id = owner_tab[i];
                        r.status = ST_OK;
                        break;
                    end
                end
                if (!r.found && c.allow_self && c.addr_second == self_cfg.self_addr
                    && c.port_second == self_cfg.self_port) begin
                    r.found = 1'b1;
                    r.owner_id = self_cfg.self_proc_id;
                    r.status = ST_SELF;
                end
            end
        endcase
        r.entry_count = entries[7:0];
        return r;
    endfunction

    assign o_pending = owner_results_q.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            entries = 0;
            self_cfg = '0;
            owner_results_q.delete();
            o_fail_count <= 0;
            o_hits <= 0;
            o_self_hits <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SELF_ADDR: self_cfg.self_addr = i_cfg_data;
                    CFG_SELF_PORT: self_cfg.self_port = i_cfg_data[15:0];
                    CFG_SELF_PID:  self_cfg.self_proc_id = i_cfg_data[22:0];
                    default: ;
                endcase
            end
            if (i_done) begin
                if (owner_results_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = owner_results_q.pop_front();
                    if (i_result.found !== want.found || i_result.owner_id !== want.owner_id
                        || i_result.status !== want.status
                        || i_result.entry_count !== want.entry_count) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, i_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (want.status == ST_OK && want.found) o_hits <= o_hits + 1;
                    if (want.status == ST_SELF) o_self_hits <= o_self_hits + 1;
                end
            end
            // done and a new accept never share an edge with a stale prediction
            if (i_start && !i_busy) owner_results_q.push_back(apply_command(i_cmd));
        end
    end
endmodule

// ===== test/socket_owner_flow_table_tb.sv =====
// Testbench top for the socket owner flow table: clock, reset, config writes and commands.
// Depends on softab_pkg, socket_owner_flow_table and socket_owner_flow_table_chk.
module socket_owner_flow_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import softab_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    t_in_item    cmd;
    logic        done;
    t_out_item   result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          hits;
    int          self_hits;
    int          sent;

    // small pools so inserts, attaches and lookups collide often
    logic [31:0] addr_pool [4] = '{32'h0A000001, 32'hC0A80101, 32'hFFFFFFFF, 32'h00000001};
    logic [15:0] port_pool [4] = '{16'd80, 16'd443, 16'hFFFF, 16'd0};

    socket_owner_flow_table dut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy), .i_cmd(cmd),
        .o_done(done), .o_result(result), .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    socket_owner_flow_table_chk chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy), .i_cmd(cmd),
        .i_done(done), .i_result(result), .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data), .o_fail_count(fail_count),
        .o_pending(pending), .o_hits(hits), .o_self_hits(self_hits)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // drop start for one cycle after each accept
    task automatic issue(t_in_item c);
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        sent++;
        @(posedge clk);
    endtask

    task automatic wait_drain();
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic t_in_item make_cmd(t_action act, logic [7:0] pr, logic [31:0] a1,
                                          logic [31:0] a2, logic [15:0] p1, logic [15:0] p2,
                                          logic [31:0] sid, logic [22:0] pid, logic ff,
                                          logic al);
        t_in_item c;
        c.action = act; c.proto = pr; c.addr_first = a1; c.addr_second = a2;
        c.port_first = p1; c.port_second = p2; c.socket_id = sid; c.proc_id = pid;
        c.fresh_fill = ff; c.allow_self = al;
        return c;
    endfunction

    function automatic t_in_item random_cmd();
        t_in_item c;
        int       pick;
        c = make_cmd(t_action'($urandom_range(0, 3)), 8'($urandom_range(5, 7)),
                     addr_pool[$urandom_range(0, 3)], addr_pool[$urandom_range(0, 3)],
                     port_pool[$urandom_range(0, 3)], port_pool[$urandom_range(0, 3)],
                     32'($urandom_range(1, 12)), 23'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) == 0) c.action = ACT_INSERT;
        if (c.action == ACT_CLEAR && $urandom_range(0, 5) != 0) c.action = ACT_LOOKUP;
        pick = $urandom_range(0, 9);
        // occasional full-width noise on every field
        if (pick == 0) c = t_in_item'(163'({$urandom, $urandom, $urandom, $urandom,
                                             $urandom, $urandom}));
        if (c.action == ACT_INSERT && $urandom_range(0, 7) == 0) c.socket_id = 0;
        if (pick == 1) c.proc_id = 23'($urandom_range(0, 4194304));
        if (pick == 2) c.proc_id = 23'd4194304;
        return c;
    endfunction

    initial begin
        t_in_item c;
        int       burst;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SELF_ADDR;
        cfg_data = '0;
        sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_SELF_ADDR, 32'hC0A80101);
        write_reg(CFG_SELF_PORT, 32'd443);
        write_reg(CFG_SELF_PID, 32'd4194304);

        // directed: every action and each special case
        issue(make_cmd(ACT_LOOKUP, 8'd6, 32'h1, 32'hC0A80101, 16'd1, 16'd443, 0, 0, 0, 1));
        issue(make_cmd(ACT_LOOKUP, 8'd6, 32'h1, 32'hC0A80101, 16'd1, 16'd443, 0, 0, 0, 0));
        issue(make_cmd(ACT_ATTACH, 8'd6, 0, 0, 0, 0, 32'd5, 23'd9, 0, 0));
        issue(make_cmd(ACT_INSERT, 8'd6, 32'h0A000001, 32'hC0A80101, 16'd80, 16'd443,
                       32'd5, 0, 0, 0));
        issue(make_cmd(ACT_INSERT, 8'd6, 0, 32'h1, 16'd1, 16'd2, 32'd6, 0, 0, 0));
        issue(make_cmd(ACT_INSERT, 8'd6, 32'h1, 0, 16'd1, 16'd2, 32'd6, 0, 0, 0));
        issue(make_cmd(ACT_INSERT, 8'd6, 32'h1, 32'h2, 16'd1, 16'd2, 32'd0, 0, 0, 0));
        issue(make_cmd(ACT_INSERT, 8'd17, 32'h1, 32'h2, 16'd1, 16'd2, 32'd5, 0, 0, 0));
        issue(make_cmd(ACT_INSERT, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
                       32'd5, 0, 1, 0));
        issue(make_cmd(ACT_LOOKUP, 8'd6, 32'hC0A80101, 32'h0A000001, 16'd443, 16'd80,
                       0, 0, 0, 1));
        issue(make_cmd(ACT_ATTACH, 8'd0, 0, 0, 0, 0, 32'd5, 23'd0, 0, 0));
        issue(make_cmd(ACT_ATTACH, 8'd0, 0, 0, 0, 0, 32'd5, 23'h7FFFFF, 0, 0));
        issue(make_cmd(ACT_ATTACH, 8'd0, 0, 0, 0, 0, 32'd5, 23'd3, 0, 0));
        issue(make_cmd(ACT_LOOKUP, 8'd6, 32'h0A000001, 32'hC0A80101, 16'd80, 16'd443,
                       0, 0, 0, 0));
        issue(make_cmd(ACT_LOOKUP, 8'd17, 32'h0A000001, 32'hC0A80101, 16'd80, 16'd443,
                       0, 0, 0, 1));
        issue(make_cmd(ACT_LOOKUP, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
                       0, 0, 0, 0));
        // fill to capacity, then three more to see full
        for (int i = 0; i < TABLE_DEPTH + 1; i++)
            issue(make_cmd(ACT_INSERT, 8'd6, 32'h1, 32'h2, 16'(i), 16'd7, 32'd100 + i,
                           0, 0, 0));
        issue(make_cmd(ACT_INSERT, 8'd6, 32'h1, 32'h2, 0, 0, 0, 0, 1, 0));
        issue(make_cmd(ACT_LOOKUP, 8'd6, 32'h2, 32'h1, 16'd7, 16'd127, 0, 0, 0, 0));
        issue(make_cmd(ACT_LOOKUP, 8'd6, 32'h9, 32'h9, 16'd7, 16'd127, 0, 0, 0, 0));
        issue(make_cmd(ACT_CLEAR, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_drain();

        // random phases, each writing the self address, port and process id anew
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(CFG_SELF_ADDR, phase == 0 ? 32'hFFFFFFFF : addr_pool[phase]);
            write_reg(CFG_SELF_PORT, phase == 1 ? 32'hFFFF : 32'(port_pool[phase]));
            write_reg(CFG_SELF_PID, phase == 3 ? 32'd0 : $urandom_range(1, 4194304));
            for (int n = 0; n < 150; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 150; b++, n++) begin
                    c = random_cmd();
                    issue(c);
                end
                if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            wait_drain();
        end

        $display("sent %0d commands over 5 settings; %0d table hits, %0d self hits",
                 sent, hits, self_hits);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
